@@ rtl/core/isp_pkg.sv @@
`timescale 1ns / 1ps

package isp_pkg;

  localparam int MAX_VALUES = 256;
  localparam int COUNT_W    = $clog2(MAX_VALUES + 1);
  localparam int VALUE_W    = 32;
  localparam int OUT_CNT_W  = 9;

  localparam logic [7:0] CH_SEP   = 8'h5C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic               in_token;
    logic               negative;
    logic               digits_open;
    logic [VALUE_W-1:0] accumulator;
    logic [COUNT_W-1:0] stored_count;
  } state_t;

  typedef struct packed {
    logic                 has_value;
    logic                 end_of_list;
    logic [VALUE_W-1:0]   value;
    logic [OUT_CNT_W-1:0] value_count;
  } result_t;

  localparam state_t STATE_RESET = '{
    in_token:     1'b0,
    negative:     1'b0,
    digits_open:  1'b1,
    accumulator:  '0,
    stored_count: '0
  };

  function automatic logic [OUT_CNT_W-1:0] sat_count(input logic [COUNT_W-1:0] c);
    logic [COUNT_W+OUT_CNT_W-1:0] wide;
    wide = {{OUT_CNT_W{1'b0}}, c};
    if (wide > (COUNT_W + OUT_CNT_W)'({OUT_CNT_W{1'b1}})) begin
      return {OUT_CNT_W{1'b1}};
    end else begin
      return wide[OUT_CNT_W-1:0];
    end
  endfunction

endpackage

@@ rtl/core/isp_token.sv @@
`timescale 1ns / 1ps

module isp_token (
  input  isp_pkg::state_t  state,
  input  logic [7:0]       byte_in,
  input  logic             last_byte,
  output isp_pkg::state_t  state_next,
  output isp_pkg::result_t result,
  output logic             produce
);

  logic                       digit;
  logic                       blank;
  logic                       sep;
  logic [isp_pkg::VALUE_W-1:0] digit_val;
  isp_pkg::state_t            took;
  logic                       emit;
  logic [isp_pkg::COUNT_W-1:0] count_next;

  always_comb begin
    digit     = (byte_in >= isp_pkg::CH_ZERO) && (byte_in <= isp_pkg::CH_NINE);
    blank     = (byte_in == isp_pkg::CH_SPACE) || (byte_in == isp_pkg::CH_TAB) ||
                (byte_in == isp_pkg::CH_LF) || (byte_in == isp_pkg::CH_CR);
    sep       = (byte_in == isp_pkg::CH_SEP);
    digit_val = {{(isp_pkg::VALUE_W-8){1'b0}}, byte_in - isp_pkg::CH_ZERO};

    took = state;
    if (!sep) begin
      if (!state.in_token) begin
        if (!blank) begin
          took.in_token = 1'b1;
          if (byte_in == isp_pkg::CH_MINUS) begin
            took.negative = 1'b1;
          end else if (byte_in == isp_pkg::CH_PLUS) begin
            took.negative = state.negative;
          end else if (digit) begin
            took.accumulator = digit_val;
          end else begin
            took.digits_open = 1'b0;
          end
        end
      end else if (state.digits_open && digit) begin
        took.accumulator = (state.accumulator << 3) + (state.accumulator << 1) + digit_val;
      end else begin
        took.digits_open = 1'b0;
      end
    end

    emit       = (sep || last_byte) && took.in_token &&
                 (took.stored_count < isp_pkg::COUNT_W'(isp_pkg::MAX_VALUES));
    count_next = emit ? took.stored_count + 1'b1 : took.stored_count;

    result.has_value   = emit;
    result.end_of_list = last_byte;
    result.value       = emit ? (took.negative ? (0 - took.accumulator) : took.accumulator)
                              : '0;
    result.value_count = isp_pkg::sat_count(count_next);
    produce            = emit || last_byte;

    state_next = took;
    if (sep || last_byte) begin
      state_next              = isp_pkg::STATE_RESET;
      state_next.stored_count = last_byte ? '0 : count_next;
    end
  end

endmodule

@@ rtl/core/isp_out_reg.sv @@
`timescale 1ns / 1ps

module isp_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  isp_pkg::result_t data,
  output logic             ready,
  output logic             result_valid,
  input  logic             result_stall,
  output isp_pkg::result_t held
);

  assign ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      held <= data;
    end
  end

endmodule

@@ rtl/core/integer_string_list_parser.sv @@
`timescale 1ns / 1ps

// Parses a backslash-separated list of signed decimal integers, one byte per
// word. Each byte is held in an input register; one that gives a result is then
// written to the result register, which drives the outputs. A new byte is taken
// every cycle while the result side keeps up. A byte that would give a result
// waits in the input register while the result register is full and stalled;
// bytes that give no result pass through regardless. A result comes for each
// backslash that closes a non-empty token while fewer than 256 values are
// stored in the list, and for the last byte of each string; after the last
// byte the parser is back at its reset state for the next string.

module integer_string_list_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  byte_in,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic signed [31:0] value,
  output logic        has_value,
  output logic        end_of_list,
  output logic [8:0]  value_count
);

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_last;
  logic             s1_go;
  logic             out_ready;
  logic             produce;
  isp_pkg::state_t  state;
  isp_pkg::state_t  state_next;
  isp_pkg::result_t res;
  isp_pkg::result_t held;

  isp_token u_token (
    .state      (state),
    .byte_in    (s1_byte),
    .last_byte  (s1_last),
    .state_next (state_next),
    .result     (res),
    .produce    (produce)
  );

  assign s1_go      = !produce || out_ready;
  assign byte_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!byte_stall) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      s1_byte <= byte_in;
      s1_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= isp_pkg::STATE_RESET;
    end else if (s1_valid && s1_go) begin
      state <= state_next;
    end
  end

  isp_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (s1_valid && produce),
    .data         (res),
    .ready        (out_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .held         (held)
  );

  assign value       = held.value;
  assign has_value   = held.has_value;
  assign end_of_list = held.end_of_list;
  assign value_count = held.value_count;

endmodule

@@ rtl/core/isp_checker.sv @@
`timescale 1ns / 1ps

module isp_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic signed [31:0] value,
  input logic        has_value,
  input logic        end_of_list,
  input logic [8:0]  value_count
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !has_value |-> value == 32'sd0)
    else $error("value not zero on result without value");

  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && !has_value |-> end_of_list)
    else $error("result without value before end of list");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && has_value |-> value_count != 9'd0)
    else $error("value given with zero count");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind integer_string_list_parser isp_checker u_isp_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .value        (value),
  .has_value    (has_value),
  .end_of_list  (end_of_list),
  .value_count  (value_count)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } text_byte_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              byte_valid = 1'b0;
  logic              byte_stall;
  logic [7:0]        byte_in = 8'h00;
  logic              last_byte = 1'b0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic signed [31:0] value;
  logic              has_value;
  logic              end_of_list;
  logic [8:0]        value_count;

  integer_string_list_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_in      (byte_in),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .value        (value),
    .has_value    (has_value),
    .end_of_list  (end_of_list),
    .value_count  (value_count)
  );

  always #5 clk = ~clk;

  text_byte_t        bytes_to_send[$];
  logic [7:0]        str_buf[$];
  isp_pkg::result_t  values_due[$];
  int                failures = 0;

  // parser state mirror
  logic        tok_open = 1'b0;
  logic        tok_neg = 1'b0;
  logic        run_open = 1'b1;
  logic [31:0] acc = '0;
  int          n_stored = 0;

  function automatic logic is_blank(input logic [7:0] b);
    return b == isp_pkg::CH_SPACE || b == isp_pkg::CH_TAB ||
           b == isp_pkg::CH_LF || b == isp_pkg::CH_CR;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic fin);
    logic             digit;
    logic             emit;
    logic [7:0]       d;
    isp_pkg::result_t r;
    digit = b >= isp_pkg::CH_ZERO && b <= isp_pkg::CH_NINE;
    d = b - isp_pkg::CH_ZERO;
    emit = 1'b0;
    r = '0;
    if (b != isp_pkg::CH_SEP) begin
      if (!tok_open) begin
        if (!is_blank(b)) begin
          tok_open = 1'b1;
          if (b == isp_pkg::CH_MINUS) begin
            tok_neg = 1'b1;
          end else if (b != isp_pkg::CH_PLUS) begin
            if (digit) begin
              acc = {24'h0, d};
            end else begin
              run_open = 1'b0;
            end
          end
        end
      end else if (run_open && digit) begin
        acc = acc * 32'd10 + {24'h0, d};
      end else begin
        run_open = 1'b0;
      end
    end
    if (b == isp_pkg::CH_SEP || fin) begin
      if (tok_open && n_stored < isp_pkg::MAX_VALUES) begin
        emit = 1'b1;
        r.value = tok_neg ? 32'd0 - acc : acc;
        n_stored++;
      end
      tok_open = 1'b0;
      tok_neg = 1'b0;
      run_open = 1'b1;
      acc = '0;
    end
    if (emit || fin) begin
      r.has_value = emit;
      r.end_of_list = fin;
      r.value_count = 9'(n_stored > 511 ? 511 : n_stored);
      values_due.push_back(r);
    end
    if (fin) n_stored = 0;
  endtask

  // stimulus building
  function automatic logic [7:0] blank();
    case ($urandom_range(0, 3))
      0: return isp_pkg::CH_SPACE;
      1: return isp_pkg::CH_TAB;
      2: return isp_pkg::CH_LF;
      default: return isp_pkg::CH_CR;
    endcase
  endfunction

  task automatic put(input logic [7:0] b);
    str_buf.push_back(b);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic send_str();
    for (int i = 0; i < str_buf.size(); i++)
      bytes_to_send.push_back('{ch: str_buf[i], fin: i == str_buf.size() - 1});
    str_buf.delete();
  endtask

  task automatic rand_token();
    int kind;
    int n;
    int s;
    repeat ($urandom_range(0, 2)) put(blank());
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      s = $urandom_range(0, 5);
      if (s < 2) put(isp_pkg::CH_MINUS);
      else if (s == 2) put(isp_pkg::CH_PLUS);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 4);
      repeat (n) put(8'(isp_pkg::CH_ZERO + $urandom_range(0, 9)));
      if ($urandom_range(0, 4) == 0) put($urandom_range(0, 1) ? blank() : 8'($urandom));
    end else if (kind == 7) begin
      put(blank());
    end else if (kind == 8) begin
      put($urandom_range(0, 1) ? isp_pkg::CH_MINUS : 8'(8'h41 + $urandom_range(0, 25)));
    end else if (kind == 9) begin
      repeat ($urandom_range(1, 4)) put(8'($urandom));
    end
  endtask

  task automatic rand_string();
    int ntok;
    ntok = $urandom_range(1, 6);
    for (int i = 0; i < ntok; i++) begin
      rand_token();
      if (i < ntok - 1 || $urandom_range(0, 3) == 0) put(isp_pkg::CH_SEP);
    end
    if (str_buf.size() == 0) put(blank());
    send_str();
  endtask

  // sender
  int   tx_gap = 0;
  logic tx_calm = 1'b0;
  logic tx_busy;
  logic tx_offer;
  text_byte_t tx_item;

  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      byte_in <= 8'h00;
      last_byte <= 1'b0;
    end else begin
      tx_busy = byte_valid;
      if (byte_valid && !byte_stall) begin
        parse_byte(byte_in, last_byte);
        tx_busy = 1'b0;
        if ($urandom_range(0, 79) == 0) tx_calm = !tx_calm;
        tx_gap = tx_calm ? 0 : $urandom_range(0, 18);
      end
      if (!tx_busy) begin
        tx_offer = 1'b0;
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (bytes_to_send.size() > 0) begin
          tx_item = bytes_to_send.pop_front();
          byte_in <= tx_item.ch;
          last_byte <= tx_item.fin;
          tx_offer = 1'b1;
        end
        byte_valid <= tx_offer;
      end
    end
  end

  // receiver
  int   rx_hold = 0;
  int   rx_taken = 0;
  logic rx_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        rx_taken++;
        if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
        // hold off long enough to back the block up into its input
        if (rx_taken == 40) rx_hold = 400;
        else rx_hold = rx_calm ? 0 : $urandom_range(0, 18);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // checker
  isp_pkg::result_t want;

  task automatic check_field(input string what, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (values_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual value %0d count %0d",
                 $time, value, value_count);
        failures++;
      end else begin
        want = values_due.pop_front();
        check_field("value", longint'($signed(want.value)), longint'(value));
        check_field("has_value", longint'(want.has_value), longint'(has_value));
        check_field("end_of_list", longint'(want.end_of_list), longint'(end_of_list));
        check_field("value_count", longint'(want.value_count), longint'(value_count));
      end
    end
  end

  initial begin
    put_text(" -12\\+7x\\");
    send_str();
    put_text("\\\t\\");
    send_str();
    put(isp_pkg::CH_MINUS);
    send_str();
    put(8'hFF);
    put(8'h00);
    send_str();
    put_text("5000000000");
    send_str();
    put(isp_pkg::CH_SPACE);
    send_str();
    while (bytes_to_send.size() < 180) rand_string();
    // overfill one list past its capacity
    repeat (isp_pkg::MAX_VALUES + 6) begin
      if ($urandom_range(0, 3) == 0) put(isp_pkg::CH_MINUS);
      put(8'(isp_pkg::CH_ZERO + $urandom_range(0, 9)));
      put(isp_pkg::CH_SEP);
    end
    put_text("42");
    send_str();
    while (bytes_to_send.size() < 930) rand_string();

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (bytes_to_send.size() > 0 || byte_valid || values_due.size() > 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0 && values_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
